// ----- hdl/ohm_pkg.sv -----
// Shared types, constants and hash function for the open-addressing hash map.
`default_nettype none
package ohm_pkg;

  localparam int SLOTS_DEF      = 256;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 64;
  localparam logic [7:0] LOAD_LIMIT_RESET = 8'd230;

  typedef enum logic [1:0] {
    REQ_PUT    = 2'd0,
    REQ_GET    = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_SCAN   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TAG_FREE = 2'd0,
    TAG_USED = 2'd1,
    TAG_TOMB = 2'd2
  } tag_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_READ,
    BK_CHECK,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key;
    logic [63:0] value;
    logic [8:0]  scan_start;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value_out;
    logic [63:0] key_out;
    logic [7:0]  slot_index;
  } rsp_t;

  // Request after the front end: masked fields plus its home slot
  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key;
    logic [63:0] value;
    logic [8:0]  scan_start;
    logic [15:0] home;
  } job_t;

  // XOR-fold of a 64-bit key in chunks of ib bits
  function automatic logic [15:0] fold_key(input logic [63:0] key, input int ib);
    logic [63:0] k;
    logic [63:0] m;
    logic [15:0] h;
    h = '0;
    k = key;
    m = (ib > 0) ? ((64'd1 << ib) - 64'd1) : 64'd0;
    for (int c = 0; c < 64; c++) begin
      h = h ^ (m[15:0] & k[15:0]);
      if (ib > 0) k = k >> ib;
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/open_addressing_hash_map.sv -----
// Top level of the open-addressing hash map with linear probing.
`default_nettype none
// Key/value table of SLOTS entries, linear probing from the XOR-folded key.
// Requests enter a two-entry front queue; the probe engine examines one slot at
// a time (registered memory read, then compare): it takes the request, reads
// and compares each slot in turn, then finishes. The engine takes no new
// request while a result waits in the one-entry output register. After reset
// the tag memory is cleared, one slot per cycle, before the first request is
// served; requests may queue meanwhile.
module open_addressing_hash_map
  import ohm_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire req_t       req,
  output logic            empty,
  input  wire logic       pop,
  output rsp_t            rsp,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);
  logic [7:0] load_limit;
  logic job_valid, job_take;
  job_t job;

  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) load_limit <= LOAD_LIMIT_RESET;
    else if (cfg_valid && cfg_ready) load_limit <= cfg_data;
  end

  ohm_front #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst, .push, .full, .req, .job_valid, .job_take, .job
  );

  ohm_back #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .load_limit, .job_valid, .job_take, .job, .empty, .pop, .rsp
  );

`ifndef SYNTHESIS
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (rsp.status == ST_OK || rsp.status == ST_ABSENT || rsp.status == ST_FULL))
    else $error("illegal status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(rsp)))
    else $error("result changed while waiting");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.status != ST_OK) |-> (rsp.value_out == '0 && rsp.key_out == '0))
    else $error("nonzero data on miss");
`endif
endmodule
`default_nettype wire

// ----- hdl/ohm_front.sv -----
// Front end: masks request fields, computes home slot, holds a two-entry queue.
`default_nettype none
module ohm_front
  import ohm_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire req_t req,
  output logic      job_valid,
  input  wire logic job_take,
  output job_t      job
);
  localparam int IB = $clog2(SLOTS + 1) - 1;
  localparam logic [63:0] KMASK = (KEY_BITS >= 64) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);
  localparam logic [63:0] VMASK = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);

  job_t q [2];
  logic [1:0] cnt;
  logic rd, wr;
  job_t nj;
  logic [15:0] h;

  // classify and hash the incoming request; the fold is below SLOTS already
  always_comb begin
    nj.req_type   = req.req_type;
    nj.key        = req.key & KMASK;
    nj.value      = req.value & VMASK;
    nj.scan_start = req.scan_start;
    h             = fold_key(req.key & KMASK, IB);
    nj.home       = h;
  end

  assign full      = (cnt == 2'd2);
  assign wr        = push && !full;
  assign job_valid = (cnt != 2'd0);
  assign rd        = job_valid && job_take;
  assign job       = q[0];

  // two-entry shifting queue
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
    if (rd) begin
      q[0] <= q[1];
      if (wr && cnt == 2'd1) q[0] <= nj;
      if (wr && cnt == 2'd2) q[1] <= nj;
    end else if (wr) begin
      if (cnt == 2'd0) q[0] <= nj;
      else q[1] <= nj;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/ohm_back.sv -----
// Back end: probe sequencer over the slot memories with a one-entry result queue.
`default_nettype none
module ohm_back
  import ohm_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] load_limit,
  input  wire logic       job_valid,
  output logic            job_take,
  input  wire job_t       job,
  output logic            empty,
  input  wire logic       pop,
  output rsp_t            rsp
);
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = AW + 1;

  logic [1:0]            tag_mem [SLOTS];
  logic [KEY_BITS-1:0]   key_mem [SLOTS];
  logic [VALUE_BITS-1:0] val_mem [SLOTS];

  bk_state_t state, state_next;
  job_t      cur;
  logic [AW-1:0] idx;
  logic [CW-1:0] steps;
  logic [8:0]    occ;
  logic [1:0]    rd_tag;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic          out_full;
  rsp_t          res;

  logic          wr_tag_en, wr_kv_en, wr_val_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_tag;
  logic          ld_job, step_on, finish, bump;
  rsp_t          res_next;

  logic is_scan, key_eq, stop, last_idx, exhausted, start_out;
  logic [AW-1:0] home_a;

  assign is_scan   = (cur.req_type == REQ_SCAN);
  assign key_eq    = (rd_key == cur.key[KEY_BITS-1:0]);
  assign home_a    = cur.home[AW-1:0];
  assign last_idx  = (32'(idx) == SLOTS - 1);
  assign exhausted = (32'(steps) == SLOTS - 1);
  assign start_out = (32'(cur.scan_start) >= SLOTS);
  assign stop      = (rd_tag == TAG_FREE) || (rd_tag == TAG_USED && key_eq);

  // memories: one read port, one write port
  always_ff @(posedge clk) begin
    rd_tag <= tag_mem[idx];
    rd_key <= key_mem[idx];
    rd_val <= val_mem[idx];
    if (wr_tag_en) tag_mem[wr_addr] <= wr_tag;
    if (wr_kv_en) key_mem[wr_addr] <= cur.key[KEY_BITS-1:0];
    if (wr_val_en) val_mem[wr_addr] <= cur.value[VALUE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_CLEAR;
    else state <= state_next;
  end

  // sequencer
  always_comb begin
    state_next = state;
    job_take = 1'b0;
    wr_tag_en = 1'b0; wr_kv_en = 1'b0; wr_val_en = 1'b0;
    wr_addr = idx; wr_tag = TAG_USED;
    ld_job = 1'b0; step_on = 1'b0; finish = 1'b0; bump = 1'b0;
    res_next = '0;
    res_next.status = ST_ABSENT;
    unique case (state)
      BK_CLEAR: begin
        wr_tag_en = 1'b1; wr_tag = TAG_FREE;
        if (last_idx) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (job_valid && !out_full) begin
          job_take = 1'b1; ld_job = 1'b1; state_next = BK_READ;
        end
      end
      BK_READ: state_next = BK_CHECK;
      BK_CHECK: begin
        if (is_scan) begin
          if (start_out) begin
            finish = 1'b1;
          end else if (rd_tag == TAG_USED) begin
            finish = 1'b1;
            res_next.status = ST_OK;
            res_next.value_out = 64'(rd_val);
            res_next.key_out = 64'(rd_key);
            res_next.slot_index = 8'(idx);
          end else if (last_idx) begin
            finish = 1'b1;
          end else begin
            step_on = 1'b1;
          end
        end else if (stop) begin
          finish = 1'b1;
          res_next.slot_index = 8'(idx);
          unique case (cur.req_type)
            REQ_PUT: begin
              if (rd_tag == TAG_USED) begin
                wr_val_en = 1'b1; res_next.status = ST_OK;
              end else if (occ < {1'b0, load_limit}) begin
                wr_tag_en = 1'b1; wr_kv_en = 1'b1; wr_val_en = 1'b1;
                bump = 1'b1; res_next.status = ST_OK;
              end else begin
                res_next.status = ST_FULL;
              end
            end
            REQ_GET: begin
              if (rd_tag == TAG_USED) begin
                res_next.status = ST_OK; res_next.value_out = 64'(rd_val);
              end
            end
            default: begin
              if (rd_tag == TAG_USED) begin
                res_next.status = ST_OK; wr_tag_en = 1'b1; wr_tag = TAG_TOMB;
              end
            end
          endcase
        end else if (exhausted) begin
          finish = 1'b1;
          res_next.slot_index = 8'(home_a);
          res_next.status = (cur.req_type == REQ_PUT) ? ST_FULL : ST_ABSENT;
        end else begin
          step_on = 1'b1;
        end
        if (finish) state_next = BK_DONE;
        else state_next = BK_READ;
      end
      BK_DONE: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // address, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      occ <= '0;
      out_full <= 1'b0;
    end else begin
      if (state == BK_CLEAR) idx <= last_idx ? '0 : idx + AW'(1);
      if (ld_job) begin
        cur <= job;
        steps <= '0;
        if (job.req_type == REQ_SCAN) idx <= 32'(job.scan_start) >= SLOTS ? '0 : AW'(job.scan_start);
        else idx <= job.home[AW-1:0];
      end
      if (step_on) begin
        idx <= last_idx ? '0 : idx + AW'(1);
        steps <= steps + CW'(1);
      end
      if (bump) occ <= occ + 9'd1;
      if (finish) begin
        res <= res_next;
        out_full <= 1'b1;
      end else if (pop && out_full) begin
        out_full <= 1'b0;
      end
    end
  end

  assign empty = !out_full;
  assign rsp   = res;
endmodule
`default_nettype wire
